/* sv/sts_pkg.sv */
// Shared types and constants for the sparse triangular solver.
// Used by sts_datapath, sts_ctrl and sparse_triangular_solve_top; no dependencies.
package sts_pkg;

  // Fixed field widths
  localparam int IDX_W  = 10;  // row / column index
  localparam int DATA_W = 32;  // Q(31-F).F values
  localparam int ACC_W  = 64;  // accumulator, 2F fraction bits

  // Default configuration
  localparam int DEF_MAX_ROWS  = 1024;
  localparam int DEF_FRAC_BITS = 16;

  // Divider steps: one quotient bit per cycle
  localparam int DIV_STEPS = ACC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // latch the item, start store read
    logic mul_en;    // register coeff * solved entry
    logic acc_en;    // subtract product from partial sum
    logic prep;      // load divider operands
    logic div_step;  // one restoring division step
    logic finish;    // saturate, store, load output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;      // latched item closes its row
    logic den_zero;  // row divisor is zero
  } dp_status_t;

  // Remainder of a narrow index by a constant modulus below 2^IDX_W,
  // one compare-subtract per index bit.
  function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] value,
                                              input logic [IDX_W:0] modulus);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = IDX_W - 1; i >= 0; i--) begin
      r = {r[IDX_W-1:0], value[i]};
      if (r >= modulus) begin
        r = r - modulus;
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

/* sv/sts_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sts_datapath.sv */
// Datapath of the sparse triangular solver: mode register, accumulator,
// multiplier, bit-serial divider, solved-entry store and output register.
// Depends on sts_pkg and sts_ram.
module sts_datapath #(
  parameter int MAX_ROWS  = sts_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = sts_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sts_pkg::dp_cmd_t           cmd,
  output sts_pkg::dp_status_t        status,
  input  logic                       upper_mode_we,
  input  logic                       upper_mode_wdata,
  input  logic [sts_pkg::IDX_W-1:0]  row_index,
  input  logic [sts_pkg::IDX_W-1:0]  col_index,
  input  logic [sts_pkg::DATA_W-1:0] coeff,
  input  logic [sts_pkg::DATA_W-1:0] rhs,
  input  logic                       row_last,
  output logic [sts_pkg::IDX_W-1:0]  out_row,
  output logic [sts_pkg::DATA_W-1:0] solution,
  output logic                       overflow
);
  import sts_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROWS);
  localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]  Q_MAX_POS = ACC_W'(S32_MAX);
  localparam logic [ACC_W-1:0]  Q_MAX_NEG = ACC_W'(S32_MIN);

  logic                upper_mode;
  logic                row_open;
  logic [ACC_W-1:0]    psum;
  logic [DATA_W-1:0]   divisor;
  logic [DATA_W-1:0]   coeff_q;
  logic [IDX_W-1:0]    row_q;
  logic [ADDR_W-1:0]   waddr_q;
  logic                use_q;
  logic                last_q;
  logic [ACC_W-1:0]    prod;
  logic [DATA_W-1:0]   entry;
  logic [ADDR_W-1:0]   col_addr;
  logic [ADDR_W-1:0]   row_addr;
  logic                col_use;
  logic [ACC_W-1:0]    psum_init;
  logic [ACC_W:0]      diff;
  logic [ACC_W-1:0]    psum_sub;

  // Divider state
  logic [ACC_W-1:0]    quo;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   den_mag;
  logic                q_neg;
  logic                num_neg;
  logic                num_nz;
  logic                den_zero_q;
  logic [DATA_W:0]     rem_sh;
  logic                rem_ge;
  logic [DATA_W-1:0]   rem_next;
  logic [DATA_W-1:0]   sol;
  logic                sol_flag;

  // Store addresses: indices wrap at MAX_ROWS
  if (MAX_ROWS >= (1 << IDX_W)) begin : g_addr_wide
    assign col_addr = ADDR_W'(col_index);
    assign row_addr = ADDR_W'(row_index);
  end else begin : g_addr_mod
    localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(MAX_ROWS);
    logic [IDX_W-1:0] col_mod;
    logic [IDX_W-1:0] row_mod;
    assign col_mod  = idx_mod(col_index, MODULUS);
    assign row_mod  = idx_mod(row_index, MODULUS);
    assign col_addr = col_mod[ADDR_W-1:0];
    assign row_addr = row_mod[ADDR_W-1:0];
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_mode <= 1'b0;
    end else if (upper_mode_we) begin
      upper_mode <= upper_mode_wdata;
    end
  end

  // Column on the side the mode uses
  assign col_use   = upper_mode ? (col_index > row_index) : (col_index < row_index);
  assign psum_init = {{(ACC_W-DATA_W){rhs[DATA_W-1]}}, rhs} << FRAC_BITS;

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      coeff_q <= coeff;
      row_q   <= row_index;
      waddr_q <= row_addr;
      use_q   <= col_use;
      last_q  <= row_last;
    end
  end

  // Solved-entry store
  sts_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.finish),
    .waddr (waddr_q),
    .wdata (sol),
    .re    (cmd.accept),
    .raddr (col_addr),
    .rdata (entry)
  );

  // Exact product, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ACC_W'($signed(coeff_q) * $signed(entry));
    end
  end

  // Saturating subtract
  assign diff = {psum[ACC_W-1], psum} - {prod[ACC_W-1], prod};
  always_comb begin
    if (diff[ACC_W] != diff[ACC_W-1]) begin
      psum_sub = diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      psum_sub = diff[ACC_W-1:0];
    end
  end

  // Row state: partial sum, divisor, open flag
  always_ff @(posedge clk) begin
    if (rst) begin
      row_open <= 1'b0;
      divisor  <= Q_ONE;
      psum     <= '0;
    end else if (cmd.accept) begin
      row_open <= 1'b1;
      if (!row_open) begin
        psum <= psum_init;
      end
      if (!col_use && (col_index == row_index)) begin
        divisor <= coeff;
      end else if (!row_open) begin
        divisor <= Q_ONE;
      end
    end else if (cmd.acc_en && use_q) begin
      psum <= psum_sub;
    end else if (cmd.finish) begin
      row_open <= 1'b0;
      divisor  <= Q_ONE;
      psum     <= '0;
    end
  end

  assign status.last     = last_q;
  assign status.den_zero = (divisor == '0);

  // Restoring division step
  assign rem_sh   = {rem, quo[ACC_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_mag};
  assign rem_next = rem_ge ? DATA_W'(rem_sh - {1'b0, den_mag}) : rem_sh[DATA_W-1:0];

  // Divider operands and iteration
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo        <= psum[ACC_W-1] ? (~psum + 1'b1) : psum;
      den_mag    <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      rem        <= '0;
      q_neg      <= psum[ACC_W-1] ^ divisor[DATA_W-1];
      num_neg    <= psum[ACC_W-1];
      num_nz     <= (psum != '0);
      den_zero_q <= (divisor == '0);
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= {quo[ACC_W-2:0], rem_ge};
    end
  end

  // Saturate quotient
  always_comb begin
    sol_flag = 1'b0;
    if (den_zero_q) begin
      sol_flag = 1'b1;
      sol      = num_neg ? S32_MIN : (num_nz ? S32_MAX : '0);
    end else if (q_neg) begin
      if (quo > Q_MAX_NEG) begin
        sol_flag = 1'b1;
        sol      = S32_MIN;
      end else begin
        sol = DATA_W'(~quo + 1'b1);
      end
    end else if (quo > Q_MAX_POS) begin
      sol_flag = 1'b1;
      sol      = S32_MAX;
    end else begin
      sol = quo[DATA_W-1:0];
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_row  <= row_q;
      solution <= sol;
      overflow <= sol_flag;
    end
  end

endmodule

/* sv/sts_ctrl.sv */
// Controller of the sparse triangular solver: item sequencing, divider step
// count and output valid. Depends on sts_pkg.
module sts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output sts_pkg::dp_cmd_t    cmd,
  input  sts_pkg::dp_status_t status
);
  import sts_pkg::*;

  typedef enum logic [5:0] {
    ST_ACCEPT = 6'b000001,
    ST_FETCH  = 6'b000010,
    ST_ACC    = 6'b000100,
    ST_PREP   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FIN    = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic              div_done;
  logic              out_free;

  assign div_done = (cnt == CNT_W'(DIV_STEPS - 1));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_ACCEPT);

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == ST_ACCEPT) && in_valid;
    cmd.mul_en   = (state == ST_FETCH);
    cmd.acc_en   = (state == ST_ACC);
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.finish   = (state == ST_FIN) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: begin
        if (in_valid) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = status.last ? ST_PREP : ST_ACCEPT;
      end
      ST_PREP: begin
        state_next = status.den_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_ACCEPT;
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

  // State, step counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= div_done ? '0 : cnt + 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free)
    else $error("result loaded over an untaken result");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> in_stall)
    else $error("second item taken before the first was processed");

  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished row produced no result");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIV) |-> (cnt == '0))
    else $error("divider step count left over");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV) && div_done) |-> $past(state == ST_DIV))
    else $error("division ended early");

endmodule

/* sv/sparse_triangular_solve_top.sv */
// Top level of the sparse triangular solver (CSR order, Q16.16 by default).
// Depends on sts_pkg, sts_ctrl and sts_datapath (which holds sts_ram).
//
// Usage:
//   Input channel (in_valid / in_stall): one matrix nonzero per item, rows in
//   dependency order, row_last on the last nonzero of each row. rhs is taken
//   from the first item of a row.
//   Output channel (out_valid / out_stall): one item per row, on row_last:
//   the row, its solved entry and the overflow flag.
//   upper_mode_we / upper_mode: selects forward (0) or backward (1) solve;
//   write it only while the block is idle.
// Sequence:
//   Each nonzero passes accept, store read and multiply, then accumulate.
//   A row_last item adds the divider operand setup, the bit-serial divider
//   (skipped for a zero divisor) and the store and load of the result.
// Reset: rst (synchronous) clears the mode, the open row and the output
//   valid; the solved-entry store is not cleared.
// Stall: a result waits in the output register while the next row's items
//   keep flowing; only the next finished row waits for the register to free.
module sparse_triangular_solve_top #(
  parameter int MAX_ROWS  = sts_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS = sts_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       upper_mode_we,
  input  logic                       upper_mode,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sts_pkg::IDX_W-1:0]  row_index,
  input  logic [sts_pkg::IDX_W-1:0]  col_index,
  input  logic [sts_pkg::DATA_W-1:0] coeff,
  input  logic [sts_pkg::DATA_W-1:0] rhs,
  input  logic                       row_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sts_pkg::IDX_W-1:0]  out_row,
  output logic [sts_pkg::DATA_W-1:0] solution,
  output logic                       overflow
);
  import sts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing
  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and storage
  sts_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .upper_mode_we    (upper_mode_we),
    .upper_mode_wdata (upper_mode),
    .row_index        (row_index),
    .col_index        (col_index),
    .coeff            (coeff),
    .rhs              (rhs),
    .row_last         (row_last),
    .out_row          (out_row),
    .solution         (solution),
    .overflow         (overflow)
  );

endmodule
